### rtl/cnlq_pkg.sv
package cnlq_pkg;

  // Kinds of input transaction, carried in tuser.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUANT = 1'b1;

  // Table modes. Any code above MODE_SPLIT searches like MODE_SPLIT.
  localparam logic [1:0] MODE_SMALL  = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_SPLIT  = 2'd2;

  // Number of entries searched in the small-table mode.
  localparam int SMALL_TABLE_LEVELS = 16;

  // 8 / (2*pi) in Q2.15: radians in Q3.13 to turns.
  localparam logic signed [17:0] PHASE_GAIN = 18'sd41722;

  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 8;
  localparam int INDEX_BITS    = 5;

  // Control part of the search token that walks along the cell chain.
  typedef struct packed {
    logic valid;
    logic upper;   // search the upper half of the table
    logic narrow;  // search only the first SMALL_TABLE_LEVELS entries
  } tok_ctrl_t;

endpackage

### rtl/cnlq_phase.sv
module cnlq_phase #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cnlq_pkg::tok_ctrl_t   ctrl_in,
  input  logic [15:0]           phase,
  output cnlq_pkg::tok_ctrl_t   ctrl_out,
  output logic [LEVEL_BITS-1:0] turn
);

  logic signed [33:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.valid) begin
      prod <= signed'(phase) * cnlq_pkg::PHASE_GAIN;
    end
  end

  // The product stays below 2^31 in magnitude, so the turn fraction is a bit
  // slice of it; adding half a turn modulo one turn just flips the top bit.
  assign turn = {~prod[30], prod[29:31-LEVEL_BITS]};

endmodule

### rtl/cnlq_cell.sv
module cnlq_cell #(
  parameter int LEVELS_PER_TABLE = 32,
  parameter int LEVEL_BITS       = 16,
  parameter int BEST_BITS        = 5,
  parameter int CELL_INDEX       = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [LEVEL_BITS-1:0] wr_value,
  input  cnlq_pkg::tok_ctrl_t   ctrl_in,
  input  logic [LEVEL_BITS-1:0] turn_in,
  input  logic [LEVEL_BITS-1:0] dist_in,
  input  logic [BEST_BITS-1:0]  best_in,
  output cnlq_pkg::tok_ctrl_t   ctrl_out,
  output logic [LEVEL_BITS-1:0] turn_out,
  output logic [LEVEL_BITS-1:0] dist_out,
  output logic [BEST_BITS-1:0]  best_out
);

  localparam int SEARCH_CNT =
    (cnlq_pkg::SMALL_TABLE_LEVELS < 2 * LEVELS_PER_TABLE) ?
    cnlq_pkg::SMALL_TABLE_LEVELS : 2 * LEVELS_PER_TABLE;
  localparam logic IN_LOW    = (CELL_INDEX < LEVELS_PER_TABLE);
  localparam logic IN_NARROW = (CELL_INDEX < SEARCH_CNT);
  localparam logic [BEST_BITS-1:0] LOCAL_LOW = BEST_BITS'(CELL_INDEX);
  localparam logic [BEST_BITS-1:0] LOCAL_UP  = BEST_BITS'(CELL_INDEX - LEVELS_PER_TABLE);
  localparam logic FIRST_LOW = (CELL_INDEX == 0);
  localparam logic FIRST_UP  = (CELL_INDEX == LEVELS_PER_TABLE);

  logic [LEVEL_BITS-1:0] level;
  logic [LEVEL_BITS-1:0] diff;
  logic [LEVEL_BITS-1:0] gap;
  logic                  active;
  logic                  first;
  logic                  take;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      level <= wr_value;
    end
  end

  always_comb begin
    diff = turn_in - level;
    // Wrapped distance; a difference of half a turn negates to itself.
    gap = diff[LEVEL_BITS-1] ? (~diff + 1'b1) : diff;
    if (ctrl_in.upper) begin
      active = ctrl_in.valid && !IN_LOW;
      first  = FIRST_UP;
    end else begin
      active = ctrl_in.valid && (ctrl_in.narrow ? IN_NARROW : IN_LOW);
      first  = FIRST_LOW;
    end
    // Strict compare keeps the lowest index on ties.
    take = active && (first || (gap < dist_in));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    turn_out <= turn_in;
    if (take) begin
      dist_out <= gap;
      best_out <= ctrl_in.upper ? LOCAL_UP : LOCAL_LOW;
    end else begin
      dist_out <= dist_in;
      best_out <= best_in;
    end
  end

endmodule

### rtl/circular_nearest_level_quantizer.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: entry_index, entry_value,
//                                                    phase, row_odd; tuser: req_type
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: level_index
// cfg       in         cfg_wr_en                     cfg_wr_data: table_mode
//
// A table write does not hold the input. A quantize transaction holds the input
// while its token passes the phase multiply, each cell of the chain of
// 2*LEVELS_PER_TABLE compare cells and the result holding stage, and until its
// result moves into the output register.
// Only one search token is in the chain at a time; s_axis_tready stays low
// from a quantize transaction until its result has moved to the output register.
// A stalled output holds the result; the next item is accepted meanwhile.
// Reset is synchronous and clears control and table_mode, not the table.
module circular_nearest_level_quantizer #(
  parameter int LEVELS_PER_TABLE = 32,
  parameter int LEVEL_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] entry_index, [21:6] entry_value, [37:22] phase, [38] row_odd
  input  logic [39:0] s_axis_tdata,
  // [0] req_type
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] level_index
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  localparam int NUM_CELLS  = 2 * LEVELS_PER_TABLE;
  localparam int SEARCH_CNT =
    (cnlq_pkg::SMALL_TABLE_LEVELS < NUM_CELLS) ? cnlq_pkg::SMALL_TABLE_LEVELS : NUM_CELLS;
  localparam int MAX_LOCAL  =
    (SEARCH_CNT > LEVELS_PER_TABLE) ? SEARCH_CNT : LEVELS_PER_TABLE;
  localparam int BEST_BITS  = $clog2(MAX_LOCAL);

  logic [5:0]  entry_index;
  logic [15:0] entry_value;
  logic [15:0] phase;
  logic        row_odd;
  logic        req_type;

  logic [1:0]  table_mode;
  logic        busy;
  logic        pend_valid;
  logic [cnlq_pkg::INDEX_BITS-1:0] pend_idx;
  logic [cnlq_pkg::INDEX_BITS-1:0] level_index;
  logic        in_acc;
  logic        quant_acc;
  logic        write_acc;
  logic        pend_move;
  logic [LEVEL_BITS-1:0] wr_value;
  cnlq_pkg::tok_ctrl_t   front_ctrl;

  cnlq_pkg::tok_ctrl_t   ctrl_c [0:NUM_CELLS];
  logic [LEVEL_BITS-1:0] turn_c [0:NUM_CELLS];
  logic [LEVEL_BITS-1:0] dist_c [0:NUM_CELLS];
  logic [BEST_BITS-1:0]  best_c [0:NUM_CELLS];
  logic [NUM_CELLS:0]    chain_v;

  assign entry_index = s_axis_tdata[5:0];
  assign entry_value = s_axis_tdata[21:6];
  assign phase       = s_axis_tdata[37:22];
  assign row_odd     = s_axis_tdata[38];
  assign req_type    = s_axis_tuser[0];

  assign s_axis_tready = !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign quant_acc     = in_acc && (req_type == cnlq_pkg::REQ_QUANT);
  assign write_acc     = in_acc && (req_type == cnlq_pkg::REQ_WRITE);
  assign wr_value      = LEVEL_BITS'(entry_value);
  assign pend_move     = pend_valid && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    front_ctrl.valid  = quant_acc;
    front_ctrl.narrow = (table_mode == cnlq_pkg::MODE_SMALL);
    front_ctrl.upper  = (table_mode != cnlq_pkg::MODE_SMALL) &&
                        (table_mode != cnlq_pkg::MODE_SINGLE) && !row_odd;
  end

  cnlq_phase #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_phase (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (front_ctrl),
    .phase    (phase),
    .ctrl_out (ctrl_c[0]),
    .turn     (turn_c[0])
  );

  assign dist_c[0]  = '0;
  assign best_c[0]  = '0;
  assign chain_v[0] = ctrl_c[0].valid;

  for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
    logic wr_en;
    assign wr_en = write_acc && (32'(entry_index) == 32'(gi));
    assign chain_v[gi+1] = ctrl_c[gi+1].valid;

    cnlq_cell #(
      .LEVELS_PER_TABLE (LEVELS_PER_TABLE),
      .LEVEL_BITS       (LEVEL_BITS),
      .BEST_BITS        (BEST_BITS),
      .CELL_INDEX       (gi)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_value (wr_value),
      .ctrl_in  (ctrl_c[gi]),
      .turn_in  (turn_c[gi]),
      .dist_in  (dist_c[gi]),
      .best_in  (best_c[gi]),
      .ctrl_out (ctrl_c[gi+1]),
      .turn_out (turn_c[gi+1]),
      .dist_out (dist_c[gi+1]),
      .best_out (best_c[gi+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_mode    <= cnlq_pkg::MODE_SMALL;
      busy          <= 1'b0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_mode <= cfg_wr_data;
      end
      if (pend_move) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      // The holding stage is always empty when a token leaves the chain.
      if (ctrl_c[NUM_CELLS].valid) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (quant_acc) begin
        busy <= 1'b1;
      end else if (pend_move) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_c[NUM_CELLS].valid) begin
      pend_idx <= cnlq_pkg::INDEX_BITS'(best_c[NUM_CELLS]);
    end
    if (pend_move) begin
      level_index <= pend_idx;
    end
  end

  assign m_axis_tdata = cnlq_pkg::OUT_DATA_BITS'(level_index);

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({pend_valid, chain_v}))
    else $error("more than one search token in flight");

  a_token_busy: assert property (@(posedge clk) disable iff (rst)
    ((|chain_v) || pend_valid) |-> busy)
    else $error("search token in flight while input is ready");

  a_quant_busy: assert property (@(posedge clk) disable iff (rst)
    quant_acc |=> (busy && ctrl_c[0].valid))
    else $error("quantize transaction did not start a search");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid ##1 m_axis_tvalid) |-> $past(pend_valid))
    else $error("result appeared without a finished search");

endmodule

### bench/tb_circular_nearest_level_quantizer.sv
module tb_circular_nearest_level_quantizer;

  localparam int LEVELS_PER_TABLE = 32;
  localparam int LEVEL_BITS       = 16;
  localparam int TABLE_DEPTH      = 2 * LEVELS_PER_TABLE;
  // Code 3 is not named in the package; it searches like the split mode.
  localparam logic [1:0] MODE_SPLIT_ALIAS = 2'd3;

  localparam int TABLE_RAMP   = 0;
  localparam int TABLE_RANDOM = 1;
  localparam int TABLE_SPREAD = 2;
  localparam int TABLE_COARSE = 3;

  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 1500;
  localparam int QUIET_LIMIT   = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;

  // Shadow copies of the block's state, updated at each accepted transaction.
  logic [LEVEL_BITS-1:0] levels_shadow [TABLE_DEPTH];
  logic [1:0]            mode_shadow = cnlq_pkg::MODE_SMALL;
  logic [cnlq_pkg::INDEX_BITS-1:0] expected_levels [$];
  logic [cnlq_pkg::INDEX_BITS-1:0] wanted_level;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  logic hold_on     = 1'b0;
  int mismatches    = 0;
  int n_checked     = 0;
  int n_writes      = 0;
  int n_quant       = 0;
  int quiet_cycles  = 0;

  circular_nearest_level_quantizer #(
    .LEVELS_PER_TABLE(LEVELS_PER_TABLE),
    .LEVEL_BITS(LEVEL_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Radians in Q3.13 to a turn fraction, with the zero phase at half a turn.
  function automatic logic [LEVEL_BITS-1:0] phase_to_turn(logic signed [15:0] ph);
    longint prod;
    prod = longint'(ph) * longint'(cnlq_pkg::PHASE_GAIN);
    return LEVEL_BITS'((prod >>> (31 - LEVEL_BITS)) + (longint'(1) << (LEVEL_BITS - 1)));
  endfunction

  function automatic logic [LEVEL_BITS-1:0] circular_gap(logic [LEVEL_BITS-1:0] p,
                                                         logic [LEVEL_BITS-1:0] t);
    logic [LEVEL_BITS-1:0] d;
    d = p - t;
    // The negation of exactly half a turn is half a turn again, as required.
    if (d[LEVEL_BITS-1]) begin
      d = -d;
    end
    return d;
  endfunction

  function automatic logic [cnlq_pkg::INDEX_BITS-1:0] nearest_level(
    logic [LEVEL_BITS-1:0] p, logic row_odd);
    int base;
    int count;
    int best;
    logic [LEVEL_BITS-1:0] best_gap;
    logic [LEVEL_BITS-1:0] gap;
    base = 0;
    best = 0;
    best_gap = '0;
    case (mode_shadow)
      cnlq_pkg::MODE_SMALL: begin
        count = cnlq_pkg::SMALL_TABLE_LEVELS;
      end
      cnlq_pkg::MODE_SINGLE: begin
        count = LEVELS_PER_TABLE;
      end
      default: begin
        count = LEVELS_PER_TABLE;
        if (!row_odd) begin
          base = LEVELS_PER_TABLE;
        end
      end
    endcase
    for (int i = 0; i < count; i++) begin
      gap = circular_gap(p, levels_shadow[base + i]);
      // Strictly smaller only, so the lowest index keeps a tie.
      if (i == 0 || gap < best_gap) begin
        best_gap = gap;
        best = i;
      end
    end
    return cnlq_pkg::INDEX_BITS'(best);
  endfunction

  function automatic logic signed [15:0] pick_phase();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one transaction from a falling edge and returns at the falling edge
  // after it was accepted.
  task automatic send_item(logic req, logic [5:0] idx, logic [15:0] val,
                           logic signed [15:0] ph, logic row_odd);
    s_axis_tvalid = 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
    end
    s_axis_tdata  = {1'b0, row_odd, ph, val, idx};
    s_axis_tuser  = req;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    if (req == cnlq_pkg::REQ_WRITE) begin
      levels_shadow[idx] = val;
      n_writes++;
    end else begin
      expected_levels.push_back(nearest_level(phase_to_turn(ph), row_odd));
      n_quant++;
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // The register may only change once the block has drained.
  task automatic set_table_mode(logic [1:0] mode);
    while (expected_levels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = mode;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    mode_shadow = mode;
  endtask

  task automatic load_table(int kind);
    logic [15:0] offset;
    logic [15:0] val;
    offset = 16'($urandom);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case (kind)
        TABLE_RAMP: begin
          if (i < LEVELS_PER_TABLE) begin
            val = (i == LEVELS_PER_TABLE - 1) ? 16'hffff : 16'(i * 2048);
          end else begin
            val = (i == TABLE_DEPTH - 1) ? 16'h8000 : 16'((i - LEVELS_PER_TABLE) * 2048 + 1024);
          end
        end
        TABLE_SPREAD: begin
          val = offset + 16'((i % LEVELS_PER_TABLE) * 2048);
        end
        TABLE_COARSE: begin
          val = {2'($urandom_range(0, 3)), 14'b0};
        end
        default: begin
          val = 16'($urandom);
        end
      endcase
      send_item(cnlq_pkg::REQ_WRITE, 6'(i), val, 16'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_directed_levels();
    logic signed [15:0] phases [6];
    logic [1:0] modes [4];
    phases = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd25736, -16'sd25736};
    modes  = '{cnlq_pkg::MODE_SMALL, cnlq_pkg::MODE_SINGLE, cnlq_pkg::MODE_SPLIT,
               MODE_SPLIT_ALIAS};
    send_idle_pct = 0;
    stall_pct = 0;
    load_table(TABLE_RAMP);
    foreach (modes[m]) begin
      set_table_mode(modes[m]);
      foreach (phases[k]) begin
        send_item(cnlq_pkg::REQ_QUANT, 6'h3f, 16'hffff, phases[k], 1'(k + m));
      end
    end
  endtask

  // Zero phase maps to half a turn, so levels placed around it make exact ties.
  task automatic test_ties();
    send_idle_pct = 0;
    stall_pct = 0;
    set_table_mode(cnlq_pkg::MODE_SMALL);
    for (int i = 0; i < cnlq_pkg::SMALL_TABLE_LEVELS; i++) begin
      send_item(cnlq_pkg::REQ_WRITE, 6'(i), 16'h0000, 16'sh0000, 1'b0);
    end
    // Every level sits exactly half a turn away.
    send_item(cnlq_pkg::REQ_QUANT, 6'h00, 16'h0000, 16'sh0000, 1'b1);
    send_item(cnlq_pkg::REQ_WRITE, 6'd5, 16'd32718, 16'sh0000, 1'b0);
    send_item(cnlq_pkg::REQ_WRITE, 6'd3, 16'd32818, 16'sh0000, 1'b0);
    send_item(cnlq_pkg::REQ_QUANT, 6'h00, 16'h0000, 16'sh0000, 1'b0);
    send_item(cnlq_pkg::REQ_WRITE, 6'd9, 16'd32768, 16'sh0000, 1'b0);
    send_item(cnlq_pkg::REQ_WRITE, 6'd7, 16'd32768, 16'sh0000, 1'b0);
    send_item(cnlq_pkg::REQ_QUANT, 6'h00, 16'h0000, 16'sh0000, 1'b1);
  endtask

  task automatic test_random_stream(logic [1:0] mode, int table_kind, int idle_pct,
                                    int stall, int count);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    set_table_mode(mode);
    load_table(table_kind);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(cnlq_pkg::REQ_WRITE, 6'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom));
      end else begin
        send_item(cnlq_pkg::REQ_QUANT, 6'($urandom), 16'($urandom), pick_phase(),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // The receiver stops for a long stretch while quantize transactions keep coming.
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    stall_pct = 0;
    set_table_mode(cnlq_pkg::MODE_SPLIT);
    fork
      begin
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end
    join_none
    for (int n = 0; n < 30; n++) begin
      send_item(cnlq_pkg::REQ_QUANT, 6'($urandom), 16'($urandom), pick_phase(),
                1'($urandom));
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= !hold_on && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_levels.size() == 0) begin
        mismatches++;
        $display("%0t: level result %0d arrived with no quantize transaction pending",
                 $time, m_axis_tdata[cnlq_pkg::INDEX_BITS-1:0]);
      end else begin
        wanted_level = expected_levels.pop_front();
        n_checked++;
        if (m_axis_tdata[cnlq_pkg::INDEX_BITS-1:0] !== wanted_level) begin
          mismatches++;
          $display("%0t: level_index expected %0d, actual %0d", $time, wanted_level,
                   m_axis_tdata[cnlq_pkg::INDEX_BITS-1:0]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results still pending", $time,
                 QUIET_LIMIT, expected_levels.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_levels();
    test_ties();
    test_random_stream(cnlq_pkg::MODE_SMALL, TABLE_RANDOM, 0, 0, 130);
    test_random_stream(cnlq_pkg::MODE_SINGLE, TABLE_SPREAD, 59, 0, 130);
    test_random_stream(cnlq_pkg::MODE_SPLIT, TABLE_COARSE, 0, 59, 130);
    test_random_stream(MODE_SPLIT_ALIAS, TABLE_RANDOM, 10, 10, 130);
    test_random_stream(cnlq_pkg::MODE_SINGLE, TABLE_COARSE, 0, 0, 130);
    test_random_stream(cnlq_pkg::MODE_SPLIT, TABLE_SPREAD, 59, 0, 130);
    test_random_stream(cnlq_pkg::MODE_SMALL, TABLE_COARSE, 0, 59, 130);
    test_random_stream(cnlq_pkg::MODE_SPLIT, TABLE_RANDOM, 10, 10, 130);
    test_output_holdoff();

    while (expected_levels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d table writes and %0d quantize transactions in all four table modes,",
             n_writes, n_quant);
    $display("with sender gaps, receiver stalls and a long output hold-off; %0d results checked.",
             n_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### circular_nearest_level_quantizer.f
rtl/cnlq_pkg.sv
rtl/cnlq_phase.sv
rtl/cnlq_cell.sv
rtl/circular_nearest_level_quantizer.sv
bench/tb_circular_nearest_level_quantizer.sv
